// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the ALU modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ----- hdl/q24a_pkg.sv -----
// Package with types, codes and helpers of the Q24.8 ALU.
package q24a_pkg;
    localparam int FRAC_BITS = 8;
    localparam int WORD_BITS = 32;
    localparam int PROD_BITS = 2 * WORD_BITS;
    localparam int DIV_NUM_BITS = WORD_BITS + FRAC_BITS + 1;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);
    // Number of quotient bits the divider resolves in each stage.
    localparam int DIV_STEP = 4;
    localparam int DIV_STAGES = (DIV_NUM_BITS + DIV_STEP - 1) / DIV_STEP;
    localparam int DIV_PAD_BITS = DIV_STAGES * DIV_STEP;
    localparam int BACK_LAT = DIV_STAGES + 3;
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + BACK_LAT + 2);

    typedef enum logic [3:0] {
        OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
        OP_INC = 4'd4, OP_DEC = 4'd5, OP_MIN = 4'd6, OP_MAX = 4'd7,
        OP_TO_INT = 4'd8, OP_FROM_INT = 4'd9
    } op_t;

    typedef struct packed {
        logic [3:0]        action;
        logic signed [31:0] operand_a;
        logic signed [31:0] operand_b;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] result;
        logic               a_less;
        logic               a_equal;
        logic               a_greater;
        logic               overflowed;
        logic               divide_by_zero;
    } out_item_t;

    // Classified request passed from the front part to the back part.
    typedef struct packed {
        logic [3:0]                   action;
        logic signed [WORD_BITS-1:0]  a;
        logic signed [WORD_BITS-1:0]  b;
        logic                         a_less;
        logic                         a_equal;
        logic                         a_greater;
        logic                         b_zero;
        logic                         neg;
    } req_t;

    localparam logic signed [WORD_BITS+1:0] WMAX =
        {{3{1'b0}}, {(WORD_BITS-1){1'b1}}};
    localparam logic signed [WORD_BITS+1:0] WMIN = ~WMAX;

    // Saturate a value carrying two guard bits to the signed word range.
    function automatic logic [WORD_BITS:0] sat_word(input logic signed [WORD_BITS+1:0] v);
        logic [WORD_BITS:0] r;
        if (v > WMAX) begin
            r = {1'b1, WMAX[WORD_BITS-1:0]};
        end else if (v < WMIN) begin
            r = {1'b1, WMIN[WORD_BITS-1:0]};
        end else begin
            r = {1'b0, v[WORD_BITS-1:0]};
        end
        return r;
    endfunction
endpackage

// ----- hdl/q24_8_fixed_point_alu.sv -----
// Top level of the Q24.8 fixed-point ALU.
// Signed Q24.8 ALU: one request per cycle is accepted while s_ready is high,
// and results return in order. Each result passes through operand preparation,
// a transfer stage, eleven divider stages that resolve four quotient bits
// each, rounding and saturation, and the output queue.
// Every operation flows through the same pipeline, and a short queue parts
// the operand check from execution.
module q24_8_fixed_point_alu (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  q24a_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output q24a_pkg::out_item_t m_data
);
    import q24a_pkg::*;

    logic q_valid, q_ready;
    req_t q_data;

    q24a_front u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data,
        .q_valid, .q_ready, .q_data
    );

    q24a_back u_back (
        .aclk, .aresetn, .q_valid, .q_ready, .q_data,
        .m_valid, .m_ready, .m_data
    );
endmodule

// ----- hdl/q24a_front.sv -----
// Front part: accepts requests, compares operands and classifies them.
module q24a_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  q24a_pkg::in_item_t s_data,
    output logic               q_valid,
    input  logic               q_ready,
    output q24a_pkg::req_t     q_data
);
    import q24a_pkg::*;

    req_t  req;
    req_t  mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [QPTR_BITS:0]   count_reg, count_next;
    logic push, pop;

    always_comb begin
        req.action    = s_data.action;
        req.a         = s_data.operand_a[WORD_BITS-1:0];
        req.b         = s_data.operand_b[WORD_BITS-1:0];
        req.a_less    = req.a < req.b;
        req.a_equal   = req.a == req.b;
        req.a_greater = req.a > req.b;
        req.b_zero    = req.b == '0;
        req.neg       = req.a[WORD_BITS-1] ^ req.b[WORD_BITS-1];
    end

    assign s_ready = count_reg != (QPTR_BITS+1)'(QUEUE_DEPTH);
    assign push    = s_valid && s_ready;
    assign q_valid = count_reg != '0;
    assign pop     = q_valid && q_ready;
    assign q_data  = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (QPTR_BITS+1)'(push) - (QPTR_BITS+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= req;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `include "assert_macros.svh"
    `ASSERT_IMP(a_count_bound, aclk, aresetn, 1'b1, count_reg <= (QPTR_BITS+1)'(QUEUE_DEPTH))
    `ASSERT_NEXT(a_push_only, aclk, aresetn, push && !pop, count_reg == $past(count_reg) + 1'b1)
    `ASSERT_NEXT(a_pop_only, aclk, aresetn, pop && !push, count_reg == $past(count_reg) - 1'b1)
endmodule

// ----- hdl/q24a_back.sv -----
// Back part: pipelined execution unit with a radix-16 divider and output queue.
module q24a_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    output logic                q_ready,
    input  q24a_pkg::req_t      q_data,
    output logic                m_valid,
    input  logic                m_ready,
    output q24a_pkg::out_item_t m_data
);
    import q24a_pkg::*;

    localparam int LAT = BACK_LAT;
    localparam int OQ_DEPTH = LAT + 2;
    localparam int OQ_PTR = $clog2(OQ_DEPTH);
    localparam int MAG_BITS = WORD_BITS + 1;
    localparam int DEN_BITS = WORD_BITS + 1;
    localparam int REM_BITS = DEN_BITS + DIV_STEP + 1;

    // Credit count: results in flight plus results held in the output queue.
    logic [CNT_BITS-1:0] credit_reg, credit_next;
    logic issue, deliver;

    // Stage 1: magnitudes and product.
    logic           s1_v_reg;
    req_t           s1_reg;
    logic signed [PROD_BITS-1:0] s1_prod_reg;
    logic [DIV_PAD_BITS-1:0] s1_num_reg;
    logic [DEN_BITS-1:0]     s1_den_reg;

    // Divider pipeline, one stage per DIV_STEP quotient bits.
    logic                    dv_v_reg   [DIV_STAGES+1];
    req_t                    dv_req_reg [DIV_STAGES+1];
    logic signed [PROD_BITS-1:0] dv_prod_reg [DIV_STAGES+1];
    logic [DIV_PAD_BITS-1:0] dv_num_reg [DIV_STAGES+1];
    logic [DEN_BITS-1:0]     dv_den_reg [DIV_STAGES+1];
    logic [REM_BITS-1:0]     dv_rem_reg [DIV_STAGES+1];
    logic [DIV_PAD_BITS-1:0] dv_quo_reg [DIV_STAGES+1];

    // Final stage.
    logic      fin_v_reg;
    out_item_t fin_reg, fin_next;

    out_item_t oq_mem [OQ_DEPTH];
    logic [OQ_PTR-1:0] oq_wr_reg, oq_rd_reg;
    logic [OQ_PTR:0]   oq_cnt_reg;

    assign q_ready = credit_reg < CNT_BITS'(OQ_DEPTH);
    assign issue   = q_valid && q_ready;
    assign m_valid = oq_cnt_reg != '0;
    assign deliver = m_valid && m_ready;
    assign m_data  = oq_mem[oq_rd_reg];
    assign credit_next = credit_reg + CNT_BITS'(issue) - CNT_BITS'(deliver);

    always_ff @(posedge aclk) begin
        s1_reg      <= q_data;
        s1_prod_reg <= PROD_BITS'(q_data.a) * PROD_BITS'(q_data.b);
        s1_num_reg  <= DIV_PAD_BITS'(MAG_BITS'(q_data.a[WORD_BITS-1] ?
                       -{q_data.a[WORD_BITS-1], q_data.a} : {1'b0, q_data.a}))
                       << FRAC_BITS;
        s1_den_reg  <= q_data.b[WORD_BITS-1] ? -{q_data.b[WORD_BITS-1], q_data.b}
                                              : {1'b0, q_data.b};
    end

    always_ff @(posedge aclk) begin
        dv_req_reg[0]  <= s1_reg;
        dv_prod_reg[0] <= s1_prod_reg;
        dv_num_reg[0]  <= s1_num_reg;
        dv_den_reg[0]  <= s1_den_reg;
        dv_rem_reg[0]  <= '0;
        dv_quo_reg[0]  <= '0;
    end

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        logic [REM_BITS-1:0]     rem;
        logic [DIV_PAD_BITS-1:0] quo, num;
        always_comb begin
            rem = dv_rem_reg[g];
            quo = dv_quo_reg[g];
            num = dv_num_reg[g];
            for (int k = 0; k < DIV_STEP; k++) begin
                rem = {rem[REM_BITS-2:0], num[DIV_PAD_BITS-1]};
                num = num << 1;
                if (rem >= REM_BITS'(dv_den_reg[g])) begin
                    rem = rem - REM_BITS'(dv_den_reg[g]);
                    quo = {quo[DIV_PAD_BITS-2:0], 1'b1};
                end else begin
                    quo = {quo[DIV_PAD_BITS-2:0], 1'b0};
                end
            end
        end
        always_ff @(posedge aclk) begin
            dv_req_reg[g+1]  <= dv_req_reg[g];
            dv_prod_reg[g+1] <= dv_prod_reg[g];
            dv_den_reg[g+1]  <= dv_den_reg[g];
            dv_num_reg[g+1]  <= num;
            dv_rem_reg[g+1]  <= rem;
            dv_quo_reg[g+1]  <= quo;
        end
    end

    always_comb begin
        logic signed [WORD_BITS+1:0] a2, b2, v;
        logic [WORD_BITS:0]          sat;
        logic [PROD_BITS-1:0]        pmag, pq;
        logic [DIV_PAD_BITS-1:0]     dq;
        logic signed [PROD_BITS+1:0] pv, dvv;
        req_t r;
        r   = dv_req_reg[DIV_STAGES];
        a2  = (WORD_BITS+2)'(r.a);
        b2  = (WORD_BITS+2)'(r.b);
        v   = '0;
        sat = '0;
        pmag = dv_prod_reg[DIV_STAGES][PROD_BITS-1] ? -dv_prod_reg[DIV_STAGES]
                                                    : dv_prod_reg[DIV_STAGES];
        pq  = (pmag + (PROD_BITS'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        pv  = r.neg ? -(PROD_BITS+2)'(pq) : (PROD_BITS+2)'(pq);
        // Round half away from zero: bump when twice the remainder reaches the divisor.
        dq  = dv_quo_reg[DIV_STAGES] +
              DIV_PAD_BITS'(({dv_rem_reg[DIV_STAGES], 1'b0}) >=
                            (REM_BITS+1)'(dv_den_reg[DIV_STAGES]));
        dvv = r.neg ? -(PROD_BITS+2)'(dq) : (PROD_BITS+2)'(dq);
        fin_next = '0;
        fin_next.a_less    = r.a_less;
        fin_next.a_equal   = r.a_equal;
        fin_next.a_greater = r.a_greater;
        case (r.action)
            OP_ADD:      sat = sat_word(a2 + b2);
            OP_SUB:      sat = sat_word(a2 - b2);
            OP_INC:      sat = sat_word(a2 + (WORD_BITS+2)'(1));
            OP_DEC:      sat = sat_word(a2 - (WORD_BITS+2)'(1));
            OP_MIN:      sat = {1'b0, r.a_greater ? r.b : r.a};
            OP_MAX:      sat = {1'b0, r.a_greater ? r.a : r.b};
            OP_TO_INT:   sat = {1'b0, WORD_BITS'(r.a >>> FRAC_BITS)};
            OP_FROM_INT: begin
                v   = a2 <<< FRAC_BITS;
                sat = (a2 > (WMAX >>> FRAC_BITS)) ? {1'b1, WMAX[WORD_BITS-1:0]} :
                      (a2 < (WMIN >>> FRAC_BITS)) ? {1'b1, WMIN[WORD_BITS-1:0]} :
                      {1'b0, v[WORD_BITS-1:0]};
            end
            OP_MUL: begin
                sat = (pv > (PROD_BITS+2)'(WMAX)) ? {1'b1, WMAX[WORD_BITS-1:0]} :
                      (pv < (PROD_BITS+2)'(WMIN)) ? {1'b1, WMIN[WORD_BITS-1:0]} :
                      {1'b0, pv[WORD_BITS-1:0]};
            end
            OP_DIV: begin
                if (r.b_zero) begin
                    fin_next.divide_by_zero = 1'b1;
                end else begin
                    sat = (dvv > (PROD_BITS+2)'(WMAX)) ? {1'b1, WMAX[WORD_BITS-1:0]} :
                          (dvv < (PROD_BITS+2)'(WMIN)) ? {1'b1, WMIN[WORD_BITS-1:0]} :
                          {1'b0, dvv[WORD_BITS-1:0]};
                end
            end
            default: sat = '0;
        endcase
        fin_next.result     = 32'(signed'(sat[WORD_BITS-1:0]));
        fin_next.overflowed = sat[WORD_BITS];
    end

    always_ff @(posedge aclk) begin
        fin_reg <= fin_next;
        if (fin_v_reg) begin
            oq_mem[oq_wr_reg] <= fin_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_v_reg   <= 1'b0;
            for (int i = 0; i <= DIV_STAGES; i++) dv_v_reg[i] <= 1'b0;
            fin_v_reg  <= 1'b0;
            credit_reg <= '0;
            oq_wr_reg  <= '0;
            oq_rd_reg  <= '0;
            oq_cnt_reg <= '0;
        end else begin
            s1_v_reg    <= issue;
            dv_v_reg[0] <= s1_v_reg;
            for (int i = 0; i < DIV_STAGES; i++) dv_v_reg[i+1] <= dv_v_reg[i];
            fin_v_reg   <= dv_v_reg[DIV_STAGES];
            credit_reg  <= credit_next;
            if (fin_v_reg) begin
                oq_wr_reg <= (oq_wr_reg == OQ_PTR'(OQ_DEPTH - 1)) ? '0 : oq_wr_reg + 1'b1;
            end
            if (deliver) begin
                oq_rd_reg <= (oq_rd_reg == OQ_PTR'(OQ_DEPTH - 1)) ? '0 : oq_rd_reg + 1'b1;
            end
            oq_cnt_reg <= oq_cnt_reg + (OQ_PTR+1)'(fin_v_reg) - (OQ_PTR+1)'(deliver);
        end
    end

    `include "assert_macros.svh"
    `ASSERT_IMP(a_oq_no_overflow, aclk, aresetn, fin_v_reg, oq_cnt_reg < (OQ_PTR+1)'(OQ_DEPTH))
    `ASSERT_IMP(a_credit_cover, aclk, aresetn, 1'b1, CNT_BITS'(oq_cnt_reg) <= credit_reg)
    `ASSERT_IMP(a_div_zero_only, aclk, aresetn, fin_v_reg && fin_reg.divide_by_zero,
                fin_reg.result == '0 && !fin_reg.overflowed)
endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the Q24.8 fixed-point ALU.
module testbench;
    import q24a_pkg::*;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    in_item_t  pending_reqs[$];
    out_item_t expected_results[$];
    int        error_count = 0;
    bit        stim_done = 1'b0;
    bit        in_fire = 1'b0;
    int        send_wait = 0;
    int        recv_wait = 0;
    int        hold_cycles = 0;
    int        accepted_count = 0;

    q24_8_fixed_point_alu u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always #1 aclk = ~aclk;

    // Saturate a wide exact value to the signed 32-bit range.
    function automatic logic signed [31:0] clamp32(input logic signed [95:0] v,
                                                   inout logic ovf);
        if (v > 96'sh7fffffff) begin
            ovf = 1'b1;
            return 32'sh7fffffff;
        end else if (v < -96'sh80000000) begin
            ovf = 1'b1;
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // Rounded quotient, half away from zero; den is positive.
    function automatic logic signed [95:0] round_quot(input logic signed [95:0] num,
                                                      input logic signed [95:0] den);
        logic signed [95:0] mag;
        logic signed [95:0] q;
        mag = (num < 0) ? -num : num;
        q = (mag * 2 + den) / (den * 2);
        return (num < 0) ? -q : q;
    endfunction

    function automatic out_item_t alu_predict(input in_item_t req);
        out_item_t          res;
        logic signed [95:0] a;
        logic signed [95:0] b;
        logic               ovf;
        ovf = 1'b0;
        a = req.operand_a;
        b = req.operand_b;
        res = '0;
        case (req.action)
            OP_ADD:      res.result = clamp32(a + b, ovf);
            OP_SUB:      res.result = clamp32(a - b, ovf);
            OP_MUL:      res.result = clamp32(round_quot(a * b, 256), ovf);
            OP_DIV: begin
                if (b == 0) begin
                    res.divide_by_zero = 1'b1;
                end else if (b < 0) begin
                    res.result = clamp32(round_quot(-(a * 256), -b), ovf);
                end else begin
                    res.result = clamp32(round_quot(a * 256, b), ovf);
                end
            end
            OP_INC:      res.result = clamp32(a + 1, ovf);
            OP_DEC:      res.result = clamp32(a - 1, ovf);
            OP_MIN:      res.result = (a > b) ? req.operand_b : req.operand_a;
            OP_MAX:      res.result = (a > b) ? req.operand_a : req.operand_b;
            OP_TO_INT:   res.result = req.operand_a >>> 8;
            OP_FROM_INT: res.result = clamp32(a * 256, ovf);
            default:     res.result = '0;
        endcase
        res.overflowed = ovf;
        res.a_less = a < b;
        res.a_equal = a == b;
        res.a_greater = a > b;
        return res;
    endfunction

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return 32'h7fffffff - $urandom_range(0, 3);
            1: return 32'h80000000 + $urandom_range(0, 3);
            2: return $urandom_range(0, 1023) - 512;
            3: return {{12{$urandom_range(0, 1) == 1}}, 20'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    task automatic add_req(input logic [3:0] act, input logic [31:0] a,
                           input logic [31:0] b);
        in_item_t req;
        req.action = act;
        req.operand_a = a;
        req.operand_b = b;
        pending_reqs.push_back(req);
    endtask

    initial begin
        logic [3:0] act;
        // Directed part: every operation, extremes, zero divisor, unused codes.
        for (int i = 0; i <= 9; i++) begin
            add_req(4'(i), 32'h7fffffff, 32'h80000000);
        end
        add_req(OP_DIV, 32'h00000100, 32'h00000000);
        add_req(OP_DIV, 32'h80000000, 32'hffffffff);
        add_req(OP_DIV, 32'h00000300, 32'hfffffe00);
        add_req(OP_MUL, 32'h80000000, 32'h80000000);
        add_req(OP_MUL, 32'h00000180, 32'hffffff80);
        add_req(OP_INC, 32'h7fffffff, 32'h7fffffff);
        add_req(OP_DEC, 32'h80000000, 32'h80000000);
        add_req(OP_TO_INT, 32'hffffff01, 32'h0);
        add_req(OP_FROM_INT, 32'hff800000, 32'h0);
        add_req(OP_FROM_INT, 32'h00800000, 32'h0);
        add_req(4'd10, 32'h5, 32'h5);
        add_req(4'd15, 32'hffffffff, 32'h0);
        for (int i = 0; i < 650; i++) begin
            act = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15))
                                                : 4'($urandom_range(0, 9));
            add_req(act, pick_operand(), ($urandom_range(0, 15) == 0) ? 32'h0
                                                                       : pick_operand());
        end
        stim_done = 1'b1;
    end

    // Driver: offers queued requests with random gaps.
    always @(negedge aclk) begin
        if (aresetn) begin
            if (in_fire) begin
                send_wait = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 12) : 0;
            end
            if (!s_valid || in_fire) begin
                if (send_wait > 0) begin
                    send_wait--;
                    s_valid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    s_data <= pending_reqs.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver ready pattern, with one long hold-off early in the run.
    always @(negedge aclk) begin
        if (aresetn) begin
            if (accepted_count == 40 && hold_cycles == 0) begin
                hold_cycles = 60;
            end
            if (hold_cycles > 1) begin
                hold_cycles--;
                m_ready <= 1'b0;
            end else if (recv_wait > 0) begin
                recv_wait--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                recv_wait = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 12) : 0;
            end
        end
    end

    // Monitor: predicts on accepted requests, checks accepted results.
    always @(posedge aclk) begin
        out_item_t exp_res;
        in_fire = aresetn && s_valid && s_ready;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_results.push_back(alu_predict(s_data));
                accepted_count++;
            end
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, m_data);
                    error_count++;
                end else begin
                    exp_res = expected_results.pop_front();
                    if (m_data !== exp_res) begin
                        $display("%0t: mismatch expected %h actual %h", $time,
                                 exp_res, m_data);
                        error_count++;
                    end
                end
            end
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        wait (stim_done);
        while (pending_reqs.size() > 0 || s_valid || expected_results.size() > 0) begin
            @(posedge aclk);
        end
        repeat (40) @(posedge aclk);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("** q24_8_fixed_point_alu: PASSED **");
        end else begin
            $display("** q24_8_fixed_point_alu: FAILED **");
        end
        $finish;
    end

    initial begin
        #200000;
        $display("** q24_8_fixed_point_alu: FAILED **");
        $finish;
    end
endmodule

// ----- sim.f -----
+incdir+hdl
hdl/q24a_pkg.sv
hdl/q24a_front.sv
hdl/q24a_back.sv
hdl/q24_8_fixed_point_alu.sv
tb/testbench.sv
